// ===== rtl/hsar_pkg.sv =====
// Shared types and constants for the heating sensor average reporter.
// No dependencies; every other rtl file imports this package.
package hsar_pkg;

  localparam int TIME_W  = 32;
  localparam int INTV_W  = 24;
  localparam int CNT_W   = 8;
  localparam int TEMP_W  = 12;
  localparam int VAL_W   = 13;
  localparam int SUM_W   = 21;
  localparam int KIND_W  = 3;
  localparam int THR_W   = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CNT_W-1:0] MAX_AVG_COUNT = 8'd255;
  // log2 of the 2 K threshold in sixteenths (32)
  localparam int TWO_K_SHIFT = 5;

  localparam logic [INTV_W-1:0] INTV_RESET = 24'd30000;
  localparam logic [CNT_W-1:0]  N_RESET    = 8'd20;
  localparam logic [THR_W-1:0]  RISE_RESET = 12'd48;
  localparam logic [THR_W-1:0]  FALL_RESET = 12'd320;
  localparam logic [VAL_W-1:0]  HW_RESET   = 13'h1380;  // -3200

  localparam int DIV_STEPS  = SUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [KIND_W-1:0] {
    KIND_HOT  = 3'd0,
    KIND_DIFF = 3'd1,
    KIND_ON   = 3'd2,
    KIND_OFF  = 3'd3,
    KIND_RET  = 3'd4,
    KIND_FLOW = 3'd5
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPORT_INTV = 3'd0,
    REG_RETURN_INTV = 3'd1,
    REG_FLOW_INTV   = 3'd2,
    REG_N_DELTA     = 3'd3,
    REG_N_RETURN    = 3'd4,
    REG_N_FLOW      = 3'd5,
    REG_RISE_K      = 3'd6,
    REG_FALL_K      = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_EVAL,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

  // One queued result: either a direct value or a sum to be averaged
  typedef struct packed {
    kind_t                   kind;
    logic                    div;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
    logic                    last;
  } cmd_t;

endpackage

// ===== rtl/hsar_fifo.sv =====
// Small word queue between the front and back parts.
// Depends on hsar_pkg (cmd_t, FIFO_DEPTH).
module hsar_fifo
  import hsar_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_word,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t pop_word
);

  cmd_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_PTR_W:0]   cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full     = (cnt_r == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_word = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

// ===== rtl/hsar_front.sv =====
// Front part: configuration registers, input capture, timers, accumulators
// and the per-word result list. Depends on hsar_pkg.
module hsar_front
  import hsar_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [TIME_W-1:0]            in_now_ms,
  input  logic                         in_link_up,
  input  logic signed [TEMP_W-1:0]     in_hot_water_temp,
  input  logic signed [TEMP_W-1:0]     in_flow_temp,
  input  logic signed [TEMP_W-1:0]     in_return_temp,
  output logic                         q_push,
  output cmd_t                         q_word,
  input  logic                         q_full
);

  // configuration
  logic [INTV_W-1:0] rep_intv_r, ret_intv_r, flw_intv_r;
  logic [CNT_W-1:0]  n_delta_r, n_ret_r, n_flw_r;
  logic [THR_W-1:0]  rise_k_r, fall_k_r;

  front_state_t state_r, state_nxt;

  // captured word
  logic [TIME_W-1:0]        now_r;
  logic                     link_r;
  logic signed [TEMP_W-1:0] hw_r, fl_r, rt_r;

  // block state
  logic [TIME_W-1:0]       last_rep_r, last_rep_nxt;
  logic [TIME_W-1:0]       last_ret_r, last_ret_nxt;
  logic [TIME_W-1:0]       last_flw_r, last_flw_nxt;
  logic signed [VAL_W-1:0] hw_rep_r, hw_rep_nxt;
  logic signed [SUM_W-1:0] dsum_r, dsum_nxt, rsum_r, rsum_nxt, fsum_r, fsum_nxt;
  logic [CNT_W-1:0]        dcnt_r, dcnt_nxt, rcnt_r, rcnt_nxt, fcnt_r, fcnt_nxt;
  logic                    heat_on_r, heat_on_nxt;

  // pending results, one bit per kind, and their captured sums
  logic [5:0]              pend_r, pend_nxt;
  logic [5:0]              sel;
  logic signed [SUM_W-1:0] cap_dsum_r, cap_rsum_r, cap_fsum_r;
  logic [CNT_W-1:0]        cap_dcnt_r, cap_rcnt_r, cap_fcnt_r;
  logic                    cap_en;

  // evaluation terms
  logic                    rep_due, ret_due, flw_due;
  logic signed [VAL_W:0]   hw_up, hw_down;
  logic signed [VAL_W-1:0] dstep;
  logic signed [SUM_W-1:0] dsum_new, rsum_new, fsum_new;
  logic [CNT_W-1:0]        dcnt_new, rcnt_new, fcnt_new;
  logic                    hw_emit, d_eval, d_above, r_eval, f_eval;
  logic [CNT_W+TWO_K_SHIFT-1:0] d_limit;

  assign in_ready = (state_r == F_IDLE);

  always_comb begin
    rep_due = (now_r - last_rep_r) > {{(TIME_W-INTV_W){1'b0}}, rep_intv_r};
    ret_due = (now_r - last_ret_r) > {{(TIME_W-INTV_W){1'b0}}, ret_intv_r};
    flw_due = (now_r - last_flw_r) > {{(TIME_W-INTV_W){1'b0}}, flw_intv_r};

    hw_up   = (VAL_W+1)'(hw_r) - (VAL_W+1)'(hw_rep_r);
    hw_down = (VAL_W+1)'(hw_rep_r) - (VAL_W+1)'(hw_r);
    hw_emit = (hw_up > $signed({{(VAL_W+1-THR_W){1'b0}}, rise_k_r})) ||
              (hw_down > $signed({{(VAL_W+1-THR_W){1'b0}}, fall_k_r}));

    dstep    = VAL_W'(fl_r) - VAL_W'(rt_r);
    dsum_new = dsum_r + SUM_W'(dstep);
    dcnt_new = dcnt_r + 1'b1;
    d_eval   = (dcnt_new >= n_delta_r) || (dcnt_new == MAX_AVG_COUNT);
    d_limit  = {dcnt_new, {TWO_K_SHIFT{1'b0}}};
    d_above  = dsum_new > $signed({{(SUM_W-CNT_W-TWO_K_SHIFT){1'b0}}, d_limit});

    rsum_new = rsum_r + SUM_W'(rt_r);
    rcnt_new = rcnt_r + 1'b1;
    r_eval   = (rcnt_new > n_ret_r) || (rcnt_new == MAX_AVG_COUNT);

    fsum_new = fsum_r + SUM_W'(fl_r);
    fcnt_new = fcnt_r + 1'b1;
    f_eval   = (fcnt_new > n_flw_r) || (fcnt_new == MAX_AVG_COUNT);
  end

  // lowest pending kind goes first
  always_comb begin
    sel = '0;
    if (pend_r[KIND_HOT]) begin
      sel[KIND_HOT] = 1'b1;
    end else if (pend_r[KIND_DIFF]) begin
      sel[KIND_DIFF] = 1'b1;
    end else if (pend_r[KIND_ON]) begin
      sel[KIND_ON] = 1'b1;
    end else if (pend_r[KIND_OFF]) begin
      sel[KIND_OFF] = 1'b1;
    end else if (pend_r[KIND_RET]) begin
      sel[KIND_RET] = 1'b1;
    end else if (pend_r[KIND_FLOW]) begin
      sel[KIND_FLOW] = 1'b1;
    end
  end

  always_comb begin
    q_word.div  = 1'b0;
    q_word.sum  = '0;
    q_word.cnt  = '0;
    q_word.kind = KIND_FLOW;
    q_word.last = ((pend_r & ~sel) == '0);
    if (sel[KIND_HOT]) begin
      q_word.kind = KIND_HOT;
      q_word.sum  = SUM_W'(hw_r);
    end else if (sel[KIND_DIFF]) begin
      q_word.kind = KIND_DIFF;
      q_word.div  = 1'b1;
      q_word.sum  = cap_dsum_r;
      q_word.cnt  = cap_dcnt_r;
    end else if (sel[KIND_ON]) begin
      q_word.kind = KIND_ON;
    end else if (sel[KIND_OFF]) begin
      q_word.kind = KIND_OFF;
    end else if (sel[KIND_RET]) begin
      q_word.kind = KIND_RET;
      q_word.div  = 1'b1;
      q_word.sum  = cap_rsum_r;
      q_word.cnt  = cap_rcnt_r;
    end else begin
      q_word.div  = 1'b1;
      q_word.sum  = cap_fsum_r;
      q_word.cnt  = cap_fcnt_r;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    last_rep_nxt = last_rep_r;
    last_ret_nxt = last_ret_r;
    last_flw_nxt = last_flw_r;
    hw_rep_nxt   = hw_rep_r;
    dsum_nxt     = dsum_r;
    dcnt_nxt     = dcnt_r;
    rsum_nxt     = rsum_r;
    rcnt_nxt     = rcnt_r;
    fsum_nxt     = fsum_r;
    fcnt_nxt     = fcnt_r;
    heat_on_nxt  = heat_on_r;
    pend_nxt     = pend_r;
    cap_en       = 1'b0;
    q_push       = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          state_nxt = F_EVAL;
        end
      end
      F_EVAL: begin
        pend_nxt = '0;
        if (!link_r) begin
          last_rep_nxt = '0;
        end else begin
          cap_en = 1'b1;
          if (rep_due) begin
            last_rep_nxt = now_r;
            if (hw_emit) begin
              pend_nxt[KIND_HOT] = 1'b1;
              hw_rep_nxt = VAL_W'(hw_r);
            end
            if (d_eval) begin
              dsum_nxt = '0;
              dcnt_nxt = '0;
              if (d_above) begin
                pend_nxt[KIND_DIFF] = 1'b1;
                pend_nxt[KIND_ON]   = !heat_on_r;
                heat_on_nxt         = 1'b1;
              end else begin
                pend_nxt[KIND_OFF] = 1'b1;
                heat_on_nxt        = 1'b0;
              end
            end else begin
              dsum_nxt = dsum_new;
              dcnt_nxt = dcnt_new;
            end
          end
          if (ret_due) begin
            last_ret_nxt = now_r;
            if (r_eval) begin
              pend_nxt[KIND_RET] = 1'b1;
              rsum_nxt = '0;
              rcnt_nxt = '0;
            end else begin
              rsum_nxt = rsum_new;
              rcnt_nxt = rcnt_new;
            end
          end
          if (flw_due) begin
            last_flw_nxt = now_r;
            if (f_eval) begin
              pend_nxt[KIND_FLOW] = 1'b1;
              fsum_nxt = '0;
              fcnt_nxt = '0;
            end else begin
              fsum_nxt = fsum_new;
              fcnt_nxt = fcnt_new;
            end
          end
        end
        state_nxt = (pend_nxt == '0) ? F_IDLE : F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push   = 1'b1;
          pend_nxt = pend_r & ~sel;
          if (pend_nxt == '0) begin
            state_nxt = F_IDLE;
          end
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_intv_r <= INTV_RESET;
      ret_intv_r <= INTV_RESET;
      flw_intv_r <= INTV_RESET;
      n_delta_r  <= N_RESET;
      n_ret_r    <= N_RESET;
      n_flw_r    <= N_RESET;
      rise_k_r   <= RISE_RESET;
      fall_k_r   <= FALL_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_REPORT_INTV: rep_intv_r <= cfg_wdata[INTV_W-1:0];
        REG_RETURN_INTV: ret_intv_r <= cfg_wdata[INTV_W-1:0];
        REG_FLOW_INTV:   flw_intv_r <= cfg_wdata[INTV_W-1:0];
        REG_N_DELTA:     n_delta_r  <= cfg_wdata[CNT_W-1:0];
        REG_N_RETURN:    n_ret_r    <= cfg_wdata[CNT_W-1:0];
        REG_N_FLOW:      n_flw_r    <= cfg_wdata[CNT_W-1:0];
        REG_RISE_K:      rise_k_r   <= cfg_wdata[THR_W-1:0];
        REG_FALL_K:      fall_k_r   <= cfg_wdata[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      last_rep_r <= '0;
      last_ret_r <= '0;
      last_flw_r <= '0;
      hw_rep_r   <= HW_RESET;
      dsum_r     <= '0;
      dcnt_r     <= '0;
      rsum_r     <= '0;
      rcnt_r     <= '0;
      fsum_r     <= '0;
      fcnt_r     <= '0;
      heat_on_r  <= 1'b0;
      pend_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      last_rep_r <= last_rep_nxt;
      last_ret_r <= last_ret_nxt;
      last_flw_r <= last_flw_nxt;
      hw_rep_r   <= hw_rep_nxt;
      dsum_r     <= dsum_nxt;
      dcnt_r     <= dcnt_nxt;
      rsum_r     <= rsum_nxt;
      rcnt_r     <= rcnt_nxt;
      fsum_r     <= fsum_nxt;
      fcnt_r     <= fcnt_nxt;
      heat_on_r  <= heat_on_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r  <= in_now_ms;
      link_r <= in_link_up;
      hw_r   <= in_hot_water_temp;
      fl_r   <= in_flow_temp;
      rt_r   <= in_return_temp;
    end
    if (cap_en) begin
      cap_dsum_r <= dsum_new;
      cap_dcnt_r <= dcnt_new;
      cap_rsum_r <= rsum_new;
      cap_rcnt_r <= rcnt_new;
      cap_fsum_r <= fsum_new;
      cap_fcnt_r <= fcnt_new;
    end
  end

endmodule

// ===== rtl/hsar_back.sv =====
// Back part: takes queued words, averages through a bit-serial divider
// and holds each result in the output register. Depends on hsar_pkg.
module hsar_back
  import hsar_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  cmd_t                    q_word,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [KIND_W-1:0]       out_kind,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_last
);

  back_state_t state_r, state_nxt;

  logic                    ov_r, ov_nxt;
  logic [KIND_W-1:0]       okind_r;
  logic signed [VAL_W-1:0] oval_r;
  logic                    olast_r;
  logic                    out_load;
  logic [KIND_W-1:0]       load_kind;
  logic signed [VAL_W-1:0] load_val;

  // divider
  logic [SUM_W-1:0]     quo_r;     // dividend shifting out, quotient in
  logic [CNT_W-1:0]     rem_r, dvs_r;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;
  logic                 neg_r;
  kind_t                dkind_r;
  logic                 dlast_r;
  logic                 div_load, div_step;
  logic [CNT_W:0]       rem_sh;
  logic                 q_bit;
  logic [SUM_W-1:0]     quo_sgn;

  assign out_valid = ov_r;
  assign out_kind  = okind_r;
  assign out_value = oval_r;
  assign out_last  = olast_r;

  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, dvs_r});
  assign quo_sgn = neg_r ? (~quo_r + 1'b1) : quo_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    load_kind = q_word.kind;
    load_val  = q_word.sum[VAL_W-1:0];
    div_load  = 1'b0;
    div_step  = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          if (q_word.div) begin
            q_pop     = 1'b1;
            div_load  = 1'b1;
            step_nxt  = '0;
            state_nxt = B_DIV;
          end else if (!ov_r || out_ready) begin
            q_pop    = 1'b1;
            out_load = 1'b1;
          end
        end
      end
      B_DIV: begin
        div_step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        load_kind = dkind_r;
        load_val  = quo_sgn[VAL_W-1:0];
        if (!ov_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    ov_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      okind_r <= load_kind;
      oval_r  <= load_val;
      olast_r <= (state_r == B_DONE) ? dlast_r : q_word.last;
    end
    if (div_load) begin
      neg_r   <= q_word.sum[SUM_W-1];
      quo_r   <= q_word.sum[SUM_W-1] ? (~q_word.sum + 1'b1) : q_word.sum;
      rem_r   <= '0;
      dvs_r   <= q_word.cnt;
      dkind_r <= q_word.kind;
      dlast_r <= q_word.last;
    end else if (div_step) begin
      rem_r <= q_bit ? CNT_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[CNT_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], q_bit};
    end
  end

endmodule

// ===== rtl/heating_sensor_average_reporter_top.sv =====
// Heating sensor average reporter. An input word is taken while the front is
// idle and evaluated in the next cycle; the results it causes (at most five)
// are then queued one per cycle, unless the queue is full, into a four-word
// queue. Hot water and heating on/off results leave the back part one per
// cycle as long as the output is accepted; each of the three averages
// (difference, return, flow) runs through a one-bit-a-cycle restoring divider
// of 21 steps, with a load before and an unload after, and the back part takes
// no new word until it is done. The front waits for the queue only when it is
// full. Averages truncate toward zero. Depends on hsar_pkg, hsar_front,
// hsar_fifo and hsar_back.
module heating_sensor_average_reporter_top
  import hsar_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration write port
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  // input words
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [TIME_W-1:0]        in_now_ms,
  input  logic                     in_link_up,
  input  logic signed [TEMP_W-1:0] in_hot_water_temp,
  input  logic signed [TEMP_W-1:0] in_flow_temp,
  input  logic signed [TEMP_W-1:0] in_return_temp,
  // result words
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [KIND_W-1:0]        out_kind,
  output logic signed [VAL_W-1:0]  out_value,
  output logic                     out_last
);

  // front -> queue -> back
  logic q_push, q_full, q_pop, q_valid;
  cmd_t q_in_word, q_out_word;

  // Front: timers, hot water check, accumulators and result list.
  hsar_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_now_ms         (in_now_ms),
    .in_link_up        (in_link_up),
    .in_hot_water_temp (in_hot_water_temp),
    .in_flow_temp      (in_flow_temp),
    .in_return_temp    (in_return_temp),
    .q_push            (q_push),
    .q_word            (q_in_word),
    .q_full            (q_full)
  );

  // Queue decouples evaluation from the divider.
  hsar_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_in_word),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_word  (q_out_word)
  );

  // Back: divider and output register.
  hsar_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_word    (q_out_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_last  (out_last)
  );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for heating_sensor_average_reporter_top.
// Holds its own predictor of the reports, a stalling sender and receiver, and the
// test tasks. Depends on hsar_pkg and the rtl top level.
`timescale 1ns / 1ps

module tb_top;
  import hsar_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 11;
  // idle time after the last report, well beyond what a word with no report needs
  localparam int SETTLE_CYCLES = 8;
  localparam int END_TAIL      = 80;
  // no handshake on either side for this long means the block has hung
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_WORDS  = 100;
  localparam int SWEEP_PHASES  = 5;
  localparam int CAP_WORDS     = 256;
  localparam int TWO_K         = 32;     // 2 K in sixteenths
  localparam int HW_START      = -3200;  // -200 degrees
  localparam int TEMP_MAX      = 2047;
  localparam int TEMP_MIN      = -2048;
  localparam int MAX_PRINTS    = 40;

  // one sensor word as it goes over the input channel
  typedef struct {
    logic [TIME_W-1:0]        now;
    logic                     link;
    logic signed [TEMP_W-1:0] hw;
    logic signed [TEMP_W-1:0] fl;
    logic signed [TEMP_W-1:0] rt;
  } sensor_word_t;

  // one report as it leaves on the result channel
  typedef struct {
    kind_t                   kind;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } report_t;

  // a full register setting
  typedef struct {
    logic [INTV_W-1:0] report_ivl;
    logic [INTV_W-1:0] return_ivl;
    logic [INTV_W-1:0] flow_ivl;
    logic [CNT_W-1:0]  n_delta;
    logic [CNT_W-1:0]  n_return;
    logic [CNT_W-1:0]  n_flow;
    logic [THR_W-1:0]  rise;
    logic [THR_W-1:0]  fall;
  } heat_cfg_t;

  // DUT ports: every input known from time zero
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_REPORT_INTV;
  logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [TIME_W-1:0]        in_now_ms = '0;
  logic                     in_link_up = 1'b0;
  logic signed [TEMP_W-1:0] in_hot_water_temp = '0;
  logic signed [TEMP_W-1:0] in_flow_temp = '0;
  logic signed [TEMP_W-1:0] in_return_temp = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [KIND_W-1:0]        out_kind;
  logic signed [VAL_W-1:0]  out_value;
  logic                     out_last;

  // predictor copy of the registers and of the block's state
  heat_cfg_t         cfg_model;
  logic [TIME_W-1:0] rep_time, ret_time, flw_time;
  int                hw_last_sent;
  int                dsum, dcnt, rsum, rcnt, fsum, fcnt;
  bit                heat_state;

  // reports predicted but not yet seen, oldest first
  report_t pending_reports[$];

  // bookkeeping
  int mismatch_count = 0;
  int words_sent = 0;
  int reports_seen = 0;
  int settings_used = 0;
  int stuck_cycles = 0;

  // sender and receiver idling controls
  bit              gaps_on = 1'b1;
  int              burst_left = 0;
  bit              rx_free_run = 1'b0;
  logic [15:0]     rx_pattern = 16'hA5C3;
  logic [6:0]      rx_epoch = '0;

  // stimulus state: running clock in ms and slowly wandering temperatures
  logic [TIME_W-1:0] clock_ms = '0;
  int                hw_walk = 600;
  int                rt_walk = 500;
  int                delta_bias = 32;

  heating_sensor_average_reporter_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_now_ms        (in_now_ms),
    .in_link_up       (in_link_up),
    .in_hot_water_temp(in_hot_water_temp),
    .in_flow_temp     (in_flow_temp),
    .in_return_temp   (in_return_temp),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_value        (out_value),
    .out_last         (out_last)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_predictor();
    cfg_model.report_ivl = 24'd30000;
    cfg_model.return_ivl = 24'd30000;
    cfg_model.flow_ivl   = 24'd30000;
    cfg_model.n_delta    = 8'd20;
    cfg_model.n_return   = 8'd20;
    cfg_model.n_flow     = 8'd20;
    cfg_model.rise       = 12'd48;
    cfg_model.fall       = 12'd320;
    rep_time     = '0;
    ret_time     = '0;
    flw_time     = '0;
    hw_last_sent = HW_START;
    dsum = 0; dcnt = 0;
    rsum = 0; rcnt = 0;
    fsum = 0; fcnt = 0;
    heat_state = 1'b0;
  endfunction

  // wrapping interval test: fires when (now - since) mod 2^32 exceeds the interval
  function automatic bit timer_elapsed(logic [TIME_W-1:0] now, logic [TIME_W-1:0] since,
                                       logic [INTV_W-1:0] ivl);
    logic [TIME_W-1:0] gap;
    gap = now - since;
    return gap > {{(TIME_W-INTV_W){1'b0}}, ivl};
  endfunction

  function automatic report_t make_report(kind_t k, int v);
    report_t r;
    r.kind  = k;
    r.value = VAL_W'(v);
    r.last  = 1'b0;
    return r;
  endfunction

  // Works out the reports one accepted sensor word causes and queues them.
  // Averages truncate toward zero, which SV integer division already does.
  function automatic void compute_reports(sensor_word_t w);
    report_t batch[$];
    int hw, fl, rt;
    int rise_lim, fall_lim, n_d, n_r, n_f, cap;
    hw = w.hw;
    fl = w.fl;
    rt = w.rt;
    rise_lim = cfg_model.rise;
    fall_lim = cfg_model.fall;
    n_d = cfg_model.n_delta;
    n_r = cfg_model.n_return;
    n_f = cfg_model.n_flow;
    cap = MAX_AVG_COUNT;

    // link down: only the report timer is cleared
    if (!w.link) begin
      rep_time = '0;
      return;
    end

    if (timer_elapsed(w.now, rep_time, cfg_model.report_ivl)) begin
      rep_time = w.now;
      if ((hw - hw_last_sent) > rise_lim || (hw_last_sent - hw) > fall_lim) begin
        batch.push_back(make_report(KIND_HOT, hw));
        hw_last_sent = hw;
      end
      dsum += fl - rt;
      dcnt++;
      if (dcnt >= n_d || dcnt >= cap) begin
        if (dsum > dcnt * TWO_K) begin
          batch.push_back(make_report(KIND_DIFF, dsum / dcnt));
          if (!heat_state) begin
            heat_state = 1'b1;
            batch.push_back(make_report(KIND_ON, 0));
          end
        end else begin
          // off goes out on every evaluation not above 2 K
          heat_state = 1'b0;
          batch.push_back(make_report(KIND_OFF, 0));
        end
        dsum = 0;
        dcnt = 0;
      end
    end

    if (timer_elapsed(w.now, ret_time, cfg_model.return_ivl)) begin
      ret_time = w.now;
      rsum += rt;
      rcnt++;
      if (rcnt > n_r || rcnt >= cap) begin
        batch.push_back(make_report(KIND_RET, rsum / rcnt));
        rsum = 0;
        rcnt = 0;
      end
    end

    if (timer_elapsed(w.now, flw_time, cfg_model.flow_ivl)) begin
      flw_time = w.now;
      fsum += fl;
      fcnt++;
      if (fcnt > n_f || fcnt >= cap) begin
        batch.push_back(make_report(KIND_FLOW, fsum / fcnt));
        fsum = 0;
        fcnt = 0;
      end
    end

    if (batch.size() > 0) batch[$].last = 1'b1;
    foreach (batch[i]) pending_reports.push_back(batch[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_error(string what);
    if (mismatch_count < MAX_PRINTS)
      $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Every accepted result word is matched against the oldest prediction.
  // Sampling at the edge sees the values of the cycle just ended.
  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_valid && out_ready) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        flag_error($sformatf("report with none expected: kind %0d value %0d last %0b",
                             out_kind, out_value, out_last));
      end else begin
        want = pending_reports.pop_front();
        if (out_kind !== want.kind)
          flag_error($sformatf("kind %0d, expected %0d", out_kind, want.kind));
        if (out_value !== want.value)
          flag_error($sformatf("value %0d, expected %0d (kind %0d)",
                               out_value, want.value, want.kind));
        if (out_last !== want.last)
          flag_error($sformatf("last %0b, expected %0b (kind %0d)",
                               out_last, want.last, want.kind));
      end
    end
  end

  // Hang detector: counts cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d reports outstanding",
                 STALL_LIMIT, pending_reports.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stalls on a rotating 16-bit pattern, re-picked each time rx_epoch wraps.
  // Some patterns are all ones so that stall-free stretches occur too.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_ready <= rx_free_run | rx_pattern[0];
    rx_epoch  <= rx_epoch + 7'd1;
    if (rx_epoch == '0) begin
      case ($urandom_range(0, 3))
        0:       rx_pattern <= 16'hFFFF;
        1:       rx_pattern <= 16'($urandom()) | 16'h0001;
        2:       rx_pattern <= 16'($urandom()) | 16'($urandom());
        default: rx_pattern <= (16'($urandom()) & 16'($urandom())) | 16'h0001;
      endcase
    end else begin
      rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and register access
  // ---------------------------------------------------------------------------

  // Drives one word and returns at the edge that takes it. Valid is left high so
  // that a following word can go out back to back; whatever runs next at this
  // edge either drives a new word or lowers valid.
  task automatic send_word(sensor_word_t w);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 7);
      burst_left = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid          <= 1'b1;
    in_now_ms         <= w.now;
    in_link_up        <= w.link;
    in_hot_water_temp <= w.hw;
    in_flow_temp      <= w.fl;
    in_return_temp    <= w.rt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    compute_reports(w);
    words_sent++;
  endtask

  task automatic send_fields(logic [TIME_W-1:0] now, logic link, int hw, int fl, int rt);
    sensor_word_t w;
    w.now  = now;
    w.link = link;
    w.hw   = TEMP_W'(hw);
    w.fl   = TEMP_W'(fl);
    w.rt   = TEMP_W'(rt);
    send_word(w);
  endtask

  // Lowers valid, waits for every predicted report, then lets the pipeline empty.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_REPORT_INTV: cfg_model.report_ivl = data[INTV_W-1:0];
      REG_RETURN_INTV: cfg_model.return_ivl = data[INTV_W-1:0];
      REG_FLOW_INTV:   cfg_model.flow_ivl   = data[INTV_W-1:0];
      REG_N_DELTA:     cfg_model.n_delta    = data[CNT_W-1:0];
      REG_N_RETURN:    cfg_model.n_return   = data[CNT_W-1:0];
      REG_N_FLOW:      cfg_model.n_flow     = data[CNT_W-1:0];
      REG_RISE_K:      cfg_model.rise       = data[THR_W-1:0];
      REG_FALL_K:      cfg_model.fall       = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  // Only called with the block idle: after reset or after wait_for_idle.
  task automatic write_config(heat_cfg_t c);
    put_reg(REG_REPORT_INTV, CFG_DATA_W'(c.report_ivl));
    put_reg(REG_RETURN_INTV, CFG_DATA_W'(c.return_ivl));
    put_reg(REG_FLOW_INTV,   CFG_DATA_W'(c.flow_ivl));
    put_reg(REG_N_DELTA,     CFG_DATA_W'(c.n_delta));
    put_reg(REG_N_RETURN,    CFG_DATA_W'(c.n_return));
    put_reg(REG_N_FLOW,      CFG_DATA_W'(c.n_flow));
    put_reg(REG_RISE_K,      CFG_DATA_W'(c.rise));
    put_reg(REG_FALL_K,      CFG_DATA_W'(c.fall));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int clamp_temp(int v);
    if (v > TEMP_MAX) return TEMP_MAX;
    if (v < TEMP_MIN) return TEMP_MIN;
    return v;
  endfunction

  function automatic logic [INTV_W-1:0] random_interval();
    case ($urandom_range(0, 5))
      0:       return '0;
      5:       return INTV_W'($urandom_range(41, 3000));
      default: return INTV_W'($urandom_range(1, 40));
    endcase
  endfunction

  // Biased towards small counts so that averages come often, with the
  // extremes now and then.
  function automatic heat_cfg_t random_config();
    heat_cfg_t c;
    c.report_ivl = random_interval();
    c.return_ivl = random_interval();
    c.flow_ivl   = random_interval();
    if ($urandom_range(0, 4) == 0) c.n_delta = $urandom_range(0, 1) ? 8'd255 : 8'd1;
    else                           c.n_delta = CNT_W'($urandom_range(1, 6));
    if ($urandom_range(0, 4) == 0) c.n_return = $urandom_range(0, 1) ? 8'd254 : 8'd0;
    else                            c.n_return = CNT_W'($urandom_range(0, 5));
    if ($urandom_range(0, 4) == 0) c.n_flow = $urandom_range(0, 1) ? 8'd254 : 8'd0;
    else                            c.n_flow = CNT_W'($urandom_range(0, 5));
    if ($urandom_range(0, 5) == 0) c.rise = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
    else                            c.rise = THR_W'($urandom_range(0, 120));
    if ($urandom_range(0, 5) == 0) c.fall = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
    else                            c.fall = THR_W'($urandom_range(0, 120));
    return c;
  endfunction

  // One random phase: mostly link-up words with wandering temperatures and time
  // steps around the configured intervals; some full-range noise, time jumps
  // across the 32-bit wrap and link drops. Link-down words are not counted.
  task automatic run_sweep_phase(heat_cfg_t c, int live_words);
    sensor_word_t w;
    int scale, live, r;
    write_config(c);
    scale = c.report_ivl;
    if (c.return_ivl > scale) scale = c.return_ivl;
    if (c.flow_ivl > scale)   scale = c.flow_ivl;
    delta_bias = $urandom_range(0, 64);
    live = 0;
    while (live < live_words) begin
      case ($urandom_range(0, 9))
        0:       ;  // same millisecond again
        7:       clock_ms = $urandom();
        8:       clock_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, scale));
        9:       clock_ms += TIME_W'($urandom_range(scale, scale + 2));
        default: clock_ms += TIME_W'($urandom_range(0, 2 * scale + 2));
      endcase
      w.now  = clock_ms;
      w.link = ($urandom_range(0, 11) != 0);
      r = $urandom_range(0, 240);
      hw_walk = clamp_temp(hw_walk + r - 120);
      r = $urandom_range(0, 60);
      rt_walk = clamp_temp(rt_walk + r - 30);
      r = $urandom_range(0, 48);
      w.hw = TEMP_W'(hw_walk);
      w.rt = TEMP_W'(rt_walk);
      w.fl = TEMP_W'(clamp_temp(rt_walk + delta_bias + r - 24));
      if ($urandom_range(0, 7) == 0) w.hw = TEMP_W'($urandom());
      if ($urandom_range(0, 7) == 0) w.fl = TEMP_W'($urandom());
      if ($urandom_range(0, 7) == 0) w.rt = TEMP_W'($urandom());
      send_word(w);
      if (w.link) live++;
    end
    wait_for_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset, 30 s intervals: the first due report sends hot water (it is far
  // above -200 degrees), a link drop clears only the report timer, and the
  // timers are checked across the 32-bit wrap. Temperature extremes throughout.
  task automatic test_power_on_defaults();
    send_fields(32'd1000,       1'b1, TEMP_MIN, 0,        0);
    send_fields(32'd30001,      1'b1, TEMP_MIN, TEMP_MAX, TEMP_MIN);
    send_fields(32'd30001,      1'b0, 0,        0,        0);
    send_fields(32'd60002,      1'b1, TEMP_MAX, TEMP_MIN, TEMP_MAX);
    send_fields(32'hFFFF_FFFF,  1'b1, 0,        -1,       -1);
    send_fields(32'h0000_7000,  1'b1, -1,       1365,     -1366);
    send_fields(32'h0000_7531,  1'b1, 1365,     -1366,    1365);
    clock_ms = 32'h0000_7531;
    wait_for_idle();
  endtask

  // Timers fire on nearly all words: the difference around 2 K (above, at and
  // just over), heating on only on entry, off on each evaluation, averages of
  // negative sums truncating toward zero, a link drop followed by time zero,
  // then an evaluation on every sample and hot water thresholds at full scale.
  task automatic test_directed_cases();
    heat_cfg_t c;
    int temps[8][3] = '{'{0, 100, 50}, '{10, 100, 60}, '{27, 80, 48}, '{27, 81, 48},
                        '{TEMP_MIN, TEMP_MAX, TEMP_MIN}, '{TEMP_MAX, TEMP_MIN, TEMP_MAX},
                        '{TEMP_MAX, -5, -3}, '{0, -7, -4}};
    c = '{24'd0, 24'd0, 24'd0, 8'd1, 8'd1, 8'd2, 12'd16, 12'd16};
    write_config(c);
    clock_ms = 32'h100;
    foreach (temps[i]) begin
      clock_ms += 1;
      send_fields(clock_ms, 1'b1, temps[i][0], temps[i][1], temps[i][2]);
    end
    clock_ms += 1;
    send_fields(clock_ms, 1'b0, 40, 90, 20);
    // report timer was cleared: at time zero it is not due, the others are
    clock_ms = 0;
    send_fields(clock_ms, 1'b1, 40, 90, 20);
    clock_ms = 1;
    send_fields(clock_ms, 1'b1, 41, 20, 90);
    wait_for_idle();

    c = '{24'd0, 24'd0, 24'd0, 8'd0, 8'd0, 8'd0, 12'd4095, 12'd4095};
    write_config(c);
    clock_ms += 1;
    send_fields(clock_ms, 1'b1, TEMP_MIN, 200, 100);
    clock_ms += 1;
    send_fields(clock_ms, 1'b1, TEMP_MAX, 0, 33);
    clock_ms += 1;
    send_fields(clock_ms, 1'b1, TEMP_MIN, 300, 267);
    wait_for_idle();
  endtask

  // Counts of 255: every average leaves on the cap rather than wrapping.
  task automatic test_count_cap();
    heat_cfg_t c;
    c = '{24'd0, 24'd0, 24'd0, 8'd255, 8'd255, 8'd255, 12'd4095, 12'd0};
    write_config(c);
    repeat (CAP_WORDS) begin
      clock_ms += 1;
      send_fields(clock_ms, 1'b1, int'($signed(TEMP_W'($urandom()))),
                  int'($signed(TEMP_W'($urandom()))), int'($signed(TEMP_W'($urandom()))));
    end
    wait_for_idle();
  endtask

  // Random phases. The first runs with no idling on either side; the last uses
  // the widest report and return intervals with count and threshold extremes.
  task automatic test_random_sweep();
    heat_cfg_t c;
    int per_phase;
    per_phase = RANDOM_WORDS / SWEEP_PHASES;
    for (int p = 0; p < SWEEP_PHASES; p++) begin
      gaps_on     = (p != 0);
      rx_free_run = (p == 0);
      if (p == SWEEP_PHASES - 1)
        c = '{24'hFF_FFFF, 24'hFF_FFFF, 24'd0, 8'd1, 8'd0, 8'd254, 12'd0, 12'd4095};
      else
        c = random_config();
      run_sweep_phase(c, per_phase);
    end
    gaps_on     = 1'b1;
    rx_free_run = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_on_defaults();
    test_directed_cases();
    test_count_cap();
    test_random_sweep();

    wait_for_idle();
    repeat (END_TAIL) @(posedge clk);

    $display("Covered %0d sensor words under %0d register settings; %0d reports checked.",
             words_sent, settings_used + 1, reports_seen);
    $display("Mismatches found: %0d", mismatch_count);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hsar_pkg.sv
rtl/hsar_fifo.sv
rtl/hsar_front.sv
rtl/hsar_back.sv
rtl/heating_sensor_average_reporter_top.sv
verif/tb_top.sv
